FILE: src/dtfp_pkg.sv
// ----------------------------------------------------------------------------
// dtfp_pkg
// Shared types and character codes for the decimal text to fixed point parser
// ----------------------------------------------------------------------------
`default_nettype none

package dtfp_pkg;

  // parse phase
  typedef enum logic [2:0] {
    PH_SKIP = 3'd0,
    PH_INT  = 3'd1,
    PH_FRAC = 3'd2,
    PH_DONE = 3'd3
  } phase_t;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // number of fraction digit weights held in the table
  localparam int unsigned MAX_WEIGHTS = 10;

endpackage

`default_nettype wire

FILE: src/decimal_text_to_fixed_point.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Parses a NUL terminated decimal string, one character per word, into a
// signed fixed-point number with saturation and no-number flags
// ----------------------------------------------------------------------------
// A terminating NUL is first loaded into the input register; out_valid rises when
// the result register loads, as that NUL leaves the input register.
// Throughput: one character per cycle; only a NUL whose result register is
// still held by a stalled output waits in the input register.
// Reset (synchronous, rst_n low): parser back to whitespace skipping, both
// pipeline registers empty.
`default_nettype none

module decimal_text_to_fixed_point
  import dtfp_pkg::*;
#(
  parameter int unsigned INT_BITS        = 31,
  parameter int unsigned FRAC_BITS       = 32,
  parameter int unsigned MAX_FRAC_DIGITS = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_ch,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [INT_BITS+FRAC_BITS:0]     out_value,
  output logic                                   out_overflow,
  output logic                                   out_no_number
);

  localparam int unsigned VAL_W = INT_BITS + FRAC_BITS + 1;
  localparam int unsigned MAG_W = INT_BITS + FRAC_BITS + 2;
  localparam int unsigned FA_W  = FRAC_BITS + 2;
  localparam int unsigned PR_W  = INT_BITS + 4;

  localparam logic [PR_W-1:0]     INT_MAX_EXT = (PR_W'(1) << INT_BITS) - PR_W'(1);
  localparam logic [INT_BITS-1:0] INT_MAX     = {INT_BITS{1'b1}};
  localparam logic [MAG_W-1:0]    MAG_MAX     =
    (MAG_W'(1) << (INT_BITS + FRAC_BITS)) - MAG_W'(1);
  localparam logic [3:0]          MAX_FD      = 4'(MAX_FRAC_DIGITS);

  // fraction digit weights, round half up of 2^FRAC_BITS / 10^k
  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] FRAC_WEIGHT [1:MAX_WEIGHTS] = '{
    FRAC_BITS'((ONE + 64'd5)           / 64'd10),
    FRAC_BITS'((ONE + 64'd50)          / 64'd100),
    FRAC_BITS'((ONE + 64'd500)         / 64'd1000),
    FRAC_BITS'((ONE + 64'd5000)        / 64'd10000),
    FRAC_BITS'((ONE + 64'd50000)       / 64'd100000),
    FRAC_BITS'((ONE + 64'd500000)      / 64'd1000000),
    FRAC_BITS'((ONE + 64'd5000000)     / 64'd10000000),
    FRAC_BITS'((ONE + 64'd50000000)    / 64'd100000000),
    FRAC_BITS'((ONE + 64'd500000000)   / 64'd1000000000),
    FRAC_BITS'((ONE + 64'd5000000000)  / 64'd10000000000)
  };

  // input register
  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_ch_r;

  // parser state
  phase_t                phase_r, phase_nxt;
  logic                  neg_r, neg_nxt;
  logic [INT_BITS-1:0]   int_r, int_nxt;
  logic [FA_W-1:0]       frac_r, frac_nxt;
  logic [3:0]            fdig_r, fdig_nxt;
  logic                  sat_r, sat_nxt;
  logic                  inval_r, inval_nxt;

  // result register
  logic                  out_vld_r, out_vld_nxt;
  logic [VAL_W-1:0]      val_r;
  logic                  ovf_r, none_r;

  // step logic
  logic                  s1_go;
  logic                  is_nul, is_digit, is_space;
  logic [3:0]            digit;
  logic [PR_W-1:0]       int_prod;
  logic [3:0]            fdig_inc;
  logic [FRAC_BITS-1:0]  weight;
  logic [FRAC_BITS+3:0]  frac_prod;
  logic [MAG_W-1:0]      mag;
  logic [VAL_W-1:0]      mag_sel;
  logic                  fin_ovf, fin_none;
  logic [VAL_W-1:0]      fin_val;

  // handshake
  assign s1_go    = s1_vld_r && !(is_nul && out_vld_r && out_stall);
  assign in_stall = s1_vld_r && !s1_go;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_valid && !in_stall) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
  end

  // character classes
  assign is_nul   = (s1_ch_r == CH_NUL);
  assign is_digit = (s1_ch_r inside {[CH_ZERO:CH_NINE]});
  assign is_space = (s1_ch_r inside {CH_SPACE, CH_TAB, CH_NL});
  assign digit    = 4'(s1_ch_r - CH_ZERO);

  // integer digit: acc * 10 + d
  assign int_prod = (PR_W'(int_r) << 3) + (PR_W'(int_r) << 1) + PR_W'(digit);

  // fraction digit weight
  assign fdig_inc  = fdig_r + 4'd1;
  assign weight    = (fdig_inc >= 4'd1 && fdig_inc <= 4'(MAX_WEIGHTS)) ?
                     FRAC_WEIGHT[fdig_inc] : '0;
  assign frac_prod = digit * weight;

  // final magnitude, clipping and sign
  always_comb begin
    mag      = (MAG_W'(int_r) << FRAC_BITS) + MAG_W'(frac_r);
    fin_ovf  = sat_r || (mag > MAG_MAX);
    fin_none = (phase_r == PH_SKIP) || inval_r;
    mag_sel  = fin_ovf ? VAL_W'(MAG_MAX) : VAL_W'(mag);
    if (fin_none) begin
      mag_sel = '0;
      fin_ovf = 1'b0;
    end
    fin_val = neg_r ? (VAL_W'(0) - mag_sel) : mag_sel;
  end

  // parser next state
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    int_nxt   = int_r;
    frac_nxt  = frac_r;
    fdig_nxt  = fdig_r;
    sat_nxt   = sat_r;
    inval_nxt = inval_r;
    if (s1_go) begin
      if (is_nul) begin
        phase_nxt = PH_SKIP;
        neg_nxt   = 1'b0;
        int_nxt   = '0;
        frac_nxt  = '0;
        fdig_nxt  = '0;
        sat_nxt   = 1'b0;
        inval_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_SKIP: begin
            if (is_space) begin
              phase_nxt = PH_SKIP;
            end else if (is_digit) begin
              phase_nxt = PH_INT;
              if (int_prod > INT_MAX_EXT) begin
                int_nxt = INT_MAX;
                sat_nxt = 1'b1;
              end else begin
                int_nxt = INT_BITS'(int_prod);
              end
            end else if (s1_ch_r == CH_POINT) begin
              phase_nxt = PH_FRAC;
            end else if (s1_ch_r == CH_MINUS) begin
              neg_nxt   = 1'b1;
              phase_nxt = PH_INT;
            end else if (s1_ch_r == CH_PLUS) begin
              phase_nxt = PH_INT;
            end else begin
              inval_nxt = 1'b1;
              phase_nxt = PH_DONE;
            end
          end
          PH_INT: begin
            if (is_digit) begin
              if (int_prod > INT_MAX_EXT) begin
                int_nxt = INT_MAX;
                sat_nxt = 1'b1;
              end else begin
                int_nxt = INT_BITS'(int_prod);
              end
            end else if (s1_ch_r == CH_POINT) begin
              phase_nxt = PH_FRAC;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              if (fdig_r < MAX_FD) begin
                fdig_nxt = fdig_inc;
                frac_nxt = frac_r + FA_W'(frac_prod);
              end
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // result valid
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_go && is_nul) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_SKIP;
      neg_r     <= 1'b0;
      int_r     <= '0;
      frac_r    <= '0;
      fdig_r    <= '0;
      sat_r     <= 1'b0;
      inval_r   <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      phase_r   <= phase_nxt;
      neg_r     <= neg_nxt;
      int_r     <= int_nxt;
      frac_r    <= frac_nxt;
      fdig_r    <= fdig_nxt;
      sat_r     <= sat_nxt;
      inval_r   <= inval_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_ch_r <= in_ch;
    end
    if (s1_go && is_nul) begin
      val_r  <= fin_val;
      ovf_r  <= fin_ovf;
      none_r <= fin_none;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_value     = val_r;
  assign out_overflow  = ovf_r;
  assign out_no_number = none_r;

  // a stall on the input only ever holds back a terminating NUL
  a_stall_only_nul: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && is_nul && out_vld_r))
    else $error("input stalled without a waiting NUL");

  // a result that reports no number carries a zero value and no overflow
  a_no_number_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && none_r) |-> (val_r == '0 && !ovf_r))
    else $error("no-number result with nonzero value");

  // after a NUL is taken the parser is back in whitespace skipping
  a_nul_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && is_nul) |=> (phase_r == PH_SKIP && int_r == '0 && frac_r == '0))
    else $error("parser not cleared after NUL");

  // fraction digit count never passes its limit
  a_fdig_limit: assert property (@(posedge clk) disable iff (!rst_n)
    fdig_r <= MAX_FD)
    else $error("fraction digit count beyond limit");

endmodule

`default_nettype wire
